### rtl/core/sitda_pkg.sv
// shared constants and types for the signed integer to decimal ascii converter
`default_nettype none

package sitda_pkg;

  localparam int unsigned ValueW      = 32;
  localparam int unsigned CharW       = 7;
  localparam int unsigned NumDigits   = 10;
  localparam int unsigned BitsPerStep = 2;
  localparam int unsigned NumSteps    = ValueW / BitsPerStep;
  localparam int unsigned StepCntW    = $clog2(NumSteps);
  localparam int unsigned DigitIdxW   = $clog2(NumDigits);

  localparam logic [CharW-1:0] CharZero  = 7'd48;
  localparam logic [CharW-1:0] CharMinus = 7'd45;

  typedef logic [NumDigits-1:0][3:0] bcd_t;

endpackage

`default_nettype wire

### rtl/core/sitda_dd_step.sv
// shift-and-add-3 unit, moves two binary bits into the bcd digits per use
`default_nettype none

module sitda_dd_step
  import sitda_pkg::*;
(
  input  bcd_t              bcd_i,
  input  logic [ValueW-1:0] bin_i,
  output bcd_t              bcd_o,
  output logic [ValueW-1:0] bin_o
);

  always_comb begin
    bcd_t                   bcd;
    logic [ValueW-1:0]      bin;
    logic [4*NumDigits-1:0] flat;
    bcd  = bcd_i;
    bin  = bin_i;
    flat = '0;
    for (int s = 0; s < BitsPerStep; s++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (bcd[d] >= 4'd5) begin
          bcd[d] = bcd[d] + 4'd3;
        end
      end
      flat = bcd;
      bcd  = {flat[4*NumDigits-2:0], bin[ValueW-1]};
      bin  = {bin[ValueW-2:0], 1'b0};
    end
    bcd_o = bcd;
    bin_o = bin;
  end

endmodule

`default_nettype wire

### rtl/core/signed_int_to_decimal_ascii.sv
// top level: signed 32-bit integer to decimal ascii character stream
//
// input channel: one beat carries value_i, a signed 32-bit integer
// output channel: one beat per ascii character, most significant first,
//   an optional '-' then the decimal digits without leading zeros;
//   last_o marks the final character of a number
// the magnitude is converted by a shared shift-and-add-3 unit that takes
//   two bits per cycle
// the first character is loaded into the output register once conversion is done
// a new number is taken only while idle; in_ready_o is low from the
//   input beat until the final character has been loaded into the output
//   register
// a receiver stall holds the output register and pauses character
//   generation; a new number is taken while the final character waits
// reset clears the sequencer and the output valid; nothing is kept
//   between numbers
`default_nettype none

module signed_int_to_decimal_ascii
  import sitda_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ValueW-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CharW-1:0]  character_o,
  output logic              last_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [StepCntW-1:0]  cnt_q, cnt_d;
  logic [DigitIdxW-1:0] dig_q, dig_d;
  logic                 neg_q, neg_d;
  logic                 sign_q, sign_d;
  bcd_t                 bcd_q, bcd_d;
  logic [ValueW-1:0]    bin_q, bin_d;
  logic                 out_valid_q, out_valid_d;
  logic [CharW-1:0]     char_q, char_d;
  logic                 last_q, last_d;

  bcd_t                 step_bcd;
  logic [ValueW-1:0]    step_bin;
  logic [DigitIdxW-1:0] lead_idx;
  logic                 slot_free;

  sitda_dd_step u_step (
    .bcd_i (bcd_q),
    .bin_i (bin_q),
    .bcd_o (step_bcd),
    .bin_o (step_bin)
  );

  // most significant nonzero digit, zero gives the units digit
  always_comb begin
    lead_idx = '0;
    for (int d = 0; d < NumDigits; d++) begin
      if (step_bcd[d] != 4'd0) begin
        lead_idx = DigitIdxW'(d);
      end
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dig_d       = dig_q;
    neg_d       = neg_q;
    sign_d      = sign_q;
    bcd_d       = bcd_q;
    bin_d       = bin_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          neg_d   = value_i[ValueW-1];
          bin_d   = value_i[ValueW-1] ? (ValueW'(0) - value_i) : value_i;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = StConv;
        end
      end
      StConv: begin
        bcd_d = step_bcd;
        bin_d = step_bin;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == StepCntW'(NumSteps - 1)) begin
          dig_d   = lead_idx;
          sign_d  = neg_q;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (sign_q) begin
            char_d = CharMinus;
            last_d = 1'b0;
            sign_d = 1'b0;
          end else begin
            char_d = CharZero + CharW'(bcd_q[dig_q]);
            last_d = (dig_q == '0);
            if (dig_q == '0) begin
              state_d = StIdle;
            end else begin
              dig_d = dig_q - 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      dig_q       <= '0;
      sign_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dig_q       <= dig_d;
      sign_q      <= sign_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    bcd_q  <= bcd_d;
    bin_q  <= bin_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

### test/signed_int_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps
// testbench for the signed integer to decimal ascii converter
module signed_int_to_decimal_ascii_tb;
  import sitda_pkg::*;

  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned FlushCycles = 40;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned HoldAfter   = 150;
  localparam int unsigned RandomItems = 405;
  localparam int unsigned TailItems   = 50;

  typedef struct packed {
    logic             last;
    logic [CharW-1:0] ch;
  } ascii_beat_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [ValueW-1:0] value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CharW-1:0]  character_o;
  logic              last_o;

  logic [ValueW-1:0] value_q[$];
  int unsigned       gap_q[$];
  bit                drain_q[$];
  ascii_beat_t       text_exp_q[$];

  int unsigned numbers_sent = 0;
  int unsigned negatives_sent = 0;
  int unsigned chars_checked = 0;
  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          tail_phase = 1'b0;
  bit          calm_rx = 1'b0;

  signed_int_to_decimal_ascii u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // expected text: optional minus, then digits most significant first
  function automatic void queue_decimal_text(input logic [ValueW-1:0] v);
    logic [ValueW-1:0] mag;
    logic [3:0]        digit [NumDigits];
    int                n;
    ascii_beat_t       b;
    mag = v[ValueW-1] ? (~v + 32'd1) : v;
    n = 0;
    do begin
      digit[n] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
      n++;
    end while (mag != '0 && n < NumDigits);
    if (v[ValueW-1]) begin
      b.ch = CharMinus;
      b.last = 1'b0;
      text_exp_q.push_back(b);
    end
    for (int i = n - 1; i >= 0; i--) begin
      b.ch = CharZero + CharW'(digit[i]);
      b.last = (i == 0);
      text_exp_q.push_back(b);
    end
  endfunction

  task automatic add_number(input logic [ValueW-1:0] v, input int unsigned gap,
                            input bit drain);
    value_q.push_back(v);
    gap_q.push_back(gap);
    drain_q.push_back(drain);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        queue_decimal_text(value_i);
        numbers_sent++;
        if (value_i[ValueW-1]) negatives_sent++;
      end
      tail_phase = value_q.size() < TailItems;
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (value_q.size() != 0 && !(drain_q[0] && text_exp_q.size() != 0)) begin
          in_valid_i <= 1'b1;
          value_i <= value_q.pop_front();
          gap_left = gap_q.pop_front();
          void'(drain_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin : rx_side
    ascii_beat_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (text_exp_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual char=%0d last=%0b",
                   $time, character_o, last_o);
          err_cnt++;
        end else begin
          want = text_exp_q.pop_front();
          if (want.ch !== character_o) begin
            $display("%0t: character mismatch, expected %0d, actual %0d",
                     $time, want.ch, character_o);
            err_cnt++;
          end
          if (want.last !== last_o) begin
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, want.last, last_o);
            err_cnt++;
          end
        end
        chars_checked++;
        if (chars_checked % 64 == 0) calm_rx = ($urandom_range(0, 2) == 0);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && chars_checked >= HoldAfter) begin
        // long back-pressure so the input side stalls
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!tail_phase && !calm_rx && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [ValueW-1:0] v;
    longint            lo;
    longint            hi;
    int unsigned       ndig;
    int unsigned       gap;
    bit                neg;
    bit                busy_gaps;

    add_number(32'h0000_0000, 0, 1'b0);
    add_number(32'h0000_0001, 0, 1'b0);
    add_number(32'hFFFF_FFFF, 0, 1'b0);
    add_number(32'd9, 0, 1'b0);
    add_number(32'd10, 0, 1'b0);
    add_number(-32'sd10, 0, 1'b0);
    add_number(-32'sd9, 0, 1'b0);
    add_number(32'h7FFF_FFFF, 0, 1'b0);
    add_number(32'h8000_0000, 0, 1'b0);
    add_number(32'h8000_0001, 0, 1'b0);
    add_number(32'd99, 0, 1'b0);
    add_number(32'd100, 0, 1'b0);
    add_number(32'd999999999, 0, 1'b0);
    add_number(32'd1000000000, 0, 1'b0);
    add_number(-32'sd1000000000, 0, 1'b0);
    add_number(32'd1999999999, 0, 1'b0);
    add_number(32'd123456789, 0, 1'b0);
    add_number(32'h5555_5555, 0, 1'b0);
    add_number(32'hAAAA_AAAA, 0, 1'b0);

    busy_gaps = 1'b1;
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 40 == 0) busy_gaps = $urandom_range(0, 1);
      if ($urandom_range(0, 3) == 0) begin
        v = $urandom;
      end else begin
        // pick a digit count first so every text length shows up
        ndig = $urandom_range(1, NumDigits);
        neg = $urandom_range(0, 1);
        lo = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (ndig == 1) lo = 0;
        if (neg && hi > 64'd2147483648) hi = 64'd2147483648;
        if (!neg && hi > 64'd2147483647) hi = 64'd2147483647;
        v = $urandom_range(32'(hi), 32'(lo));
        if (neg) v = ~v + 32'd1;
      end
      gap = 0;
      if (busy_gaps && i < RandomItems - TailItems && $urandom_range(0, 2) == 0)
        gap = $urandom_range(1, 17);
      add_number(v, gap, (i == 0) || (i == RandomItems / 2));
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (value_q.size() != 0 || in_valid_i || text_exp_q.size() != 0) @(posedge clk_i);
    repeat (FlushCycles) @(posedge clk_i);

    $display("converted %0d numbers (%0d negative), checked %0d characters",
             numbers_sent, negatives_sent, chars_checked);
    $display("random stalls on both sides, one long output hold, two full drains");
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
